// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Same-cycle check failed.");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Next-cycle check failed.");

`endif

// ----- hdl/pnpf_pkg.sv -----
// ----------------------------------------------------------------------------
// Petri net engine package
// Field widths, request codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package pnpf_pkg;

  localparam int DEF_MAX_PLACES      = 16;
  localparam int DEF_MAX_TRANSITIONS = 16;
  localparam int DEF_MAX_INPUT_ARCS  = 64;
  localparam int DEF_MAX_OUTPUT_ARCS = 64;

  localparam int OP_W     = 3;
  localparam int ENTRY_W  = 6;
  localparam int ID_W     = 4;
  localparam int TOKEN_W  = 16;
  localparam int SUM_W    = 40;
  localparam int ARC_W    = ID_W + ID_W + TOKEN_W;
  localparam int PLACE_W  = SUM_W + TOKEN_W;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
  localparam logic [OP_W-1:0] OP_ARC_IN  = 3'd1;
  localparam logic [OP_W-1:0] OP_ARC_OUT = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  localparam logic [1:0] REG_PLACE_COUNT      = 2'd0;
  localparam logic [1:0] REG_TRANSITION_COUNT = 2'd1;
  localparam logic [1:0] REG_INPUT_ARC_COUNT  = 2'd2;
  localparam logic [1:0] REG_OUTPUT_ARC_COUNT = 2'd3;

endpackage

`default_nettype wire

// ----- hdl/petri_net_priority_firing.sv -----
// ----------------------------------------------------------------------------
// Petri net priority firing engine
// A step walks the places, the input arcs, the transitions and then the input
// and output arcs of the lowest-numbered enabled transition, all through the
// single read port of the place memory and arc memory. Reset is synchronous;
// per-place valid bits make markings and sums read as zero, arc entries are
// undefined until written. One request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module petri_net_priority_firing #(
  parameter int MAX_PLACES      = pnpf_pkg::DEF_MAX_PLACES,
  parameter int MAX_TRANSITIONS = pnpf_pkg::DEF_MAX_TRANSITIONS,
  parameter int MAX_INPUT_ARCS  = pnpf_pkg::DEF_MAX_INPUT_ARCS,
  parameter int MAX_OUTPUT_ARCS = pnpf_pkg::DEF_MAX_OUTPUT_ARCS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pnpf_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pnpf_pkg::DATA_W-1:0]    pwdata,
  output logic      [pnpf_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire logic [pnpf_pkg::OP_W-1:0]      op,
  input  wire logic [pnpf_pkg::ENTRY_W-1:0]   entry_index,
  input  wire logic [pnpf_pkg::ID_W-1:0]      place_id,
  input  wire logic [pnpf_pkg::ID_W-1:0]      transition_id,
  input  wire logic [pnpf_pkg::TOKEN_W-1:0]   amount,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic                                fired,
  output logic      [pnpf_pkg::ID_W-1:0]      fired_transition,
  output logic      [pnpf_pkg::TOKEN_W-1:0]   place_tokens,
  output logic      [pnpf_pkg::SUM_W-1:0]     place_token_sum
);

  localparam int PW = $clog2(MAX_PLACES);
  localparam int TW = $clog2(MAX_TRANSITIONS);
  localparam int ARC_DEPTH = MAX_INPUT_ARCS + MAX_OUTPUT_ARCS;
  localparam int AW = $clog2(ARC_DEPTH);
  localparam int MAX_PT = (MAX_PLACES > MAX_TRANSITIONS) ? MAX_PLACES : MAX_TRANSITIONS;
  localparam int MAX_IO = (MAX_INPUT_ARCS > MAX_OUTPUT_ARCS) ? MAX_INPUT_ARCS : MAX_OUTPUT_ARCS;
  localparam int CNT_MAX = (MAX_PT > MAX_IO) ? MAX_PT : MAX_IO;
  localparam int CNTW = $clog2(CNT_MAX + 1);
  localparam int TOK_W = pnpf_pkg::TOKEN_W;
  localparam int SUM_W = pnpf_pkg::SUM_W;
  localparam int ID_W = pnpf_pkg::ID_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ARC_WR, S_READ_ISSUE, S_READ_DATA, S_ACC, S_ENABLE,
    S_SCAN, S_FIRE_IN, S_FIRE_OUT, S_DELIVER
  } state_t;

  typedef enum logic [1:0] {K_ACC, K_EN, K_FIN, K_FOUT} kind_t;

  state_t state;

  logic [4:0] place_count;
  logic [4:0] transition_count;
  logic [6:0] input_arc_count;
  logic [6:0] output_arc_count;

  logic [pnpf_pkg::OP_W-1:0]    req_op;
  logic [pnpf_pkg::ENTRY_W-1:0] req_entry;
  logic [ID_W-1:0]              req_place;
  logic [ID_W-1:0]              req_trans;
  logic [TOK_W-1:0]             req_amount;

  logic [pnpf_pkg::PLACE_W-1:0] place_mem [MAX_PLACES];
  logic [pnpf_pkg::ARC_W-1:0]   arc_mem [ARC_DEPTH];
  logic [MAX_PLACES-1:0]        place_valid;

  logic                         pm_we;
  logic [PW-1:0]                pm_waddr;
  logic [pnpf_pkg::PLACE_W-1:0] pm_wdata;
  logic [PW-1:0]                pm_raddr;
  logic [pnpf_pkg::PLACE_W-1:0] pm_rdata;
  logic                         pm_rvalid;
  logic [PW-1:0]                rd_addr_q;
  logic                         wr_q_valid;
  logic [PW-1:0]                wr_q_addr;
  logic [pnpf_pkg::PLACE_W-1:0] wr_q_data;
  logic [pnpf_pkg::PLACE_W-1:0] pm_eff;

  logic                         am_we;
  logic [AW-1:0]                am_waddr;
  logic [pnpf_pkg::ARC_W-1:0]   am_wdata;
  logic [AW-1:0]                am_raddr;
  logic [pnpf_pkg::ARC_W-1:0]   am_rdata;

  logic [CNTW-1:0]              cnt;
  logic [CNTW-1:0]              np_lim;
  logic [CNTW-1:0]              nt_lim;
  logic [CNTW-1:0]              nin_lim;
  logic [CNTW-1:0]              nout_lim;

  logic                         s1_valid;
  kind_t                        s1_kind;
  logic                         s2_valid;
  kind_t                        s2_kind;
  logic [TOK_W-1:0]             s2_weight;
  logic [ID_W-1:0]              s2_trans;

  logic                         arc_issue;
  kind_t                        arc_kind;
  logic                         acc_issue;
  logic [ID_W-1:0]              arc_place;
  logic [ID_W-1:0]              arc_trans;
  logic [TOK_W-1:0]             arc_weight;
  logic                         arc_hit;
  logic [TOK_W-1:0]             cur_tok;
  logic [SUM_W-1:0]             cur_sum;
  logic [SUM_W:0]               sum_add;
  logic [TOK_W:0]               tok_add;
  logic                         en_fail;

  logic [MAX_TRANSITIONS-1:0]   disabled;
  logic [TW-1:0]                fire_t;

  logic                         done_fired;
  logic [ID_W-1:0]              done_trans;
  logic [TOK_W-1:0]             done_tokens;
  logic [SUM_W-1:0]             done_sum;

  assign pready = 1'b1;
  assign req_ready = (state == S_IDLE);

  assign np_lim   = (32'(place_count) > MAX_PLACES) ? CNTW'(MAX_PLACES) : CNTW'(place_count);
  assign nt_lim   = (32'(transition_count) > MAX_TRANSITIONS) ?
                    CNTW'(MAX_TRANSITIONS) : CNTW'(transition_count);
  assign nin_lim  = (32'(input_arc_count) > MAX_INPUT_ARCS) ?
                    CNTW'(MAX_INPUT_ARCS) : CNTW'(input_arc_count);
  assign nout_lim = (32'(output_arc_count) > MAX_OUTPUT_ARCS) ?
                    CNTW'(MAX_OUTPUT_ARCS) : CNTW'(output_arc_count);

  always_comb begin
    case (paddr[3:2])
      pnpf_pkg::REG_PLACE_COUNT:      prdata = 32'(place_count);
      pnpf_pkg::REG_TRANSITION_COUNT: prdata = 32'(transition_count);
      pnpf_pkg::REG_INPUT_ARC_COUNT:  prdata = 32'(input_arc_count);
      default:                        prdata = 32'(output_arc_count);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      place_count      <= 5'd16;
      transition_count <= 5'd16;
      input_arc_count  <= 7'd0;
      output_arc_count <= 7'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        pnpf_pkg::REG_PLACE_COUNT:      place_count      <= pwdata[4:0];
        pnpf_pkg::REG_TRANSITION_COUNT: transition_count <= pwdata[4:0];
        pnpf_pkg::REG_INPUT_ARC_COUNT:  input_arc_count  <= pwdata[6:0];
        pnpf_pkg::REG_OUTPUT_ARC_COUNT: output_arc_count <= pwdata[6:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      place_mem[pm_waddr] <= pm_wdata;
    end
    pm_rdata  <= place_mem[pm_raddr];
    pm_rvalid <= place_valid[pm_raddr];
    rd_addr_q <= pm_raddr;
    wr_q_addr <= pm_waddr;
    wr_q_data <= pm_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      place_valid <= '0;
      wr_q_valid  <= 1'b0;
    end else begin
      wr_q_valid <= pm_we;
      if (pm_we) begin
        place_valid[pm_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (am_we) begin
      arc_mem[am_waddr] <= am_wdata;
    end
    am_rdata <= arc_mem[am_raddr];
  end

  always_comb begin
    pm_eff = (wr_q_valid && wr_q_addr == rd_addr_q) ? wr_q_data :
             (pm_rvalid ? pm_rdata : '0);
    cur_tok = pm_eff[TOK_W-1:0];
    cur_sum = pm_eff[pnpf_pkg::PLACE_W-1:TOK_W];
    sum_add = {1'b0, cur_sum} + (SUM_W + 1)'(cur_tok);
    tok_add = {1'b0, cur_tok} + {1'b0, s2_weight};
    en_fail = cur_tok < s2_weight;

    arc_place  = am_rdata[ID_W-1:0];
    arc_trans  = am_rdata[2*ID_W-1:ID_W];
    arc_weight = am_rdata[pnpf_pkg::ARC_W-1:2*ID_W];
    arc_hit    = s1_valid && (32'(arc_place) < MAX_PLACES) &&
                 (s1_kind == K_EN || 32'(arc_trans) == 32'(fire_t));

    arc_issue = 1'b0;
    arc_kind  = K_EN;
    am_raddr  = '0;
    acc_issue = 1'b0;
    pm_raddr  = '0;
    pm_we     = 1'b0;
    pm_waddr  = rd_addr_q;
    pm_wdata  = '0;
    am_we     = 1'b0;
    am_waddr  = '0;
    am_wdata  = {req_amount, req_trans, req_place};

    unique case (state)
      S_ACC: begin
        if (cnt < np_lim) begin
          acc_issue = 1'b1;
          pm_raddr  = PW'(cnt);
        end
      end
      S_ENABLE: begin
        if (cnt < nin_lim) begin
          arc_issue = 1'b1;
          arc_kind  = K_EN;
          am_raddr  = AW'(cnt);
        end
      end
      S_FIRE_IN: begin
        if (cnt < nin_lim) begin
          arc_issue = 1'b1;
          arc_kind  = K_FIN;
          am_raddr  = AW'(cnt);
        end
      end
      S_FIRE_OUT: begin
        if (cnt < nout_lim) begin
          arc_issue = 1'b1;
          arc_kind  = K_FOUT;
          am_raddr  = AW'(MAX_INPUT_ARCS) + AW'(cnt);
        end
      end
      S_READ_ISSUE: begin
        pm_raddr = PW'(req_place);
      end
      S_LOAD: begin
        if (32'(req_place) < MAX_PLACES) begin
          pm_we    = 1'b1;
          pm_waddr = PW'(req_place);
          pm_wdata = {{SUM_W{1'b0}}, req_amount};
        end
      end
      S_ARC_WR: begin
        if (req_op == pnpf_pkg::OP_ARC_IN) begin
          am_we    = 32'(req_entry) < MAX_INPUT_ARCS;
          am_waddr = AW'(req_entry);
        end else begin
          am_we    = 32'(req_entry) < MAX_OUTPUT_ARCS;
          am_waddr = AW'(MAX_INPUT_ARCS) + AW'(req_entry);
        end
      end
      default: begin
      end
    endcase

    if (arc_hit) begin
      pm_raddr = PW'(arc_place);
    end

    if (s2_valid) begin
      case (s2_kind)
        K_ACC: begin
          pm_we    = 1'b1;
          pm_wdata = {(sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0]), cur_tok};
        end
        K_FIN: begin
          pm_we    = 1'b1;
          pm_wdata = {cur_sum, (en_fail ? {TOK_W{1'b0}} : cur_tok - s2_weight)};
        end
        K_FOUT: begin
          pm_we    = 1'b1;
          pm_wdata = {cur_sum, (tok_add[TOK_W] ? {TOK_W{1'b1}} : tok_add[TOK_W-1:0])};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
      disabled  <= '0;
    end else begin
      s1_valid <= arc_issue;
      s1_kind  <= arc_kind;
      s2_valid <= arc_hit || acc_issue;
      s2_kind  <= arc_hit ? s1_kind : K_ACC;
      s2_weight <= arc_weight;
      s2_trans  <= arc_trans;

      if (s2_valid && s2_kind == K_EN && en_fail) begin
        for (int j = 0; j < MAX_TRANSITIONS; j++) begin
          if (32'(s2_trans) == 32'(j)) begin
            disabled[j] <= 1'b1;
          end
        end
      end

      if (res_valid && res_ready && state != S_DELIVER) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_op      <= op;
            req_entry   <= entry_index;
            req_place   <= place_id;
            req_trans   <= transition_id;
            req_amount  <= amount;
            done_fired  <= 1'b0;
            done_trans  <= '0;
            done_tokens <= '0;
            done_sum    <= '0;
            disabled    <= '0;
            cnt         <= '0;
            unique case (op) inside
              pnpf_pkg::OP_LOAD:                       state <= S_LOAD;
              pnpf_pkg::OP_ARC_IN, pnpf_pkg::OP_ARC_OUT: state <= S_ARC_WR;
              pnpf_pkg::OP_STEP:                       state <= S_ACC;
              pnpf_pkg::OP_READ:                       state <= S_READ_ISSUE;
              default:                                 state <= S_DELIVER;
            endcase
          end
        end
        S_LOAD, S_ARC_WR: begin
          state <= S_DELIVER;
        end
        S_READ_ISSUE: begin
          state <= S_READ_DATA;
        end
        S_READ_DATA: begin
          if (32'(req_place) < MAX_PLACES) begin
            done_tokens <= cur_tok;
            done_sum    <= cur_sum;
          end
          state <= S_DELIVER;
        end
        S_ACC: begin
          if (cnt < np_lim) begin
            cnt <= cnt + 1'b1;
          end else begin
            cnt   <= '0;
            state <= S_ENABLE;
          end
        end
        S_ENABLE: begin
          if (cnt < nin_lim) begin
            cnt <= cnt + 1'b1;
          end else if (!s1_valid && !s2_valid) begin
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt < nt_lim) begin
            if (!disabled[TW'(cnt)]) begin
              fire_t     <= TW'(cnt);
              done_trans <= ID_W'(cnt);
              cnt        <= '0;
              state      <= S_FIRE_IN;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else begin
            state <= S_DELIVER;
          end
        end
        S_FIRE_IN: begin
          if (cnt < nin_lim) begin
            cnt <= cnt + 1'b1;
          end else begin
            cnt   <= '0;
            state <= S_FIRE_OUT;
          end
        end
        S_FIRE_OUT: begin
          if (cnt < nout_lim) begin
            cnt <= cnt + 1'b1;
          end else if (!s1_valid && !s2_valid) begin
            done_fired <= 1'b1;
            state      <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (!res_valid || res_ready) begin
            res_valid        <= 1'b1;
            fired            <= done_fired;
            fired_transition <= done_trans;
            place_tokens     <= done_tokens;
            place_token_sum  <= done_sum;
            state            <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pnpf_checker.sv -----
// ----------------------------------------------------------------------------
// Petri net engine port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pnpf_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_valid,
  input wire logic                         req_ready,
  input wire logic                         res_valid,
  input wire logic                         res_ready,
  input wire logic                         fired,
  input wire logic [pnpf_pkg::ID_W-1:0]    fired_transition,
  input wire logic [pnpf_pkg::TOKEN_W-1:0] place_tokens,
  input wire logic [pnpf_pkg::SUM_W-1:0]   place_token_sum
);

  `ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready)
  `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(place_token_sum))
  `ASSERT_IMPLIES(a_fired_no_place, res_valid && fired, place_tokens == 0 && place_token_sum == 0)
  `ASSERT_IMPLIES(a_idle_trans_zero, res_valid && !fired, fired_transition == 0)

endmodule

bind petri_net_priority_firing pnpf_checker u_pnpf_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req_valid),
  .req_ready        (req_ready),
  .res_valid        (res_valid),
  .res_ready        (res_ready),
  .fired            (fired),
  .fired_transition (fired_transition),
  .place_tokens     (place_tokens),
  .place_token_sum  (place_token_sum)
);

`default_nettype wire
